// File: hw/rtl/vsr_pkg.sv
// Shared types and constants for the Voigt stress rotation core.
// No dependencies.
`default_nettype none
package vsr_pkg;

   typedef logic signed [31:0] stress_type;
   typedef logic [47:0] basis_col_type;

   typedef enum logic [2:0] {
      CSR_FROM_COL_X = 3'd0,
      CSR_FROM_COL_Y = 3'd1,
      CSR_FROM_COL_Z = 3'd2,
      CSR_TO_COL_X   = 3'd3,
      CSR_TO_COL_Y   = 3'd4,
      CSR_TO_COL_Z   = 3'd5
   } csr_index_type;

   // Voigt order xx, yy, zz, yz, zx, xy as tensor index pairs
   localparam int VOIGT_P [6] = '{0, 1, 2, 1, 0, 0};
   localparam int VOIGT_Q [6] = '{0, 1, 2, 2, 2, 1};

   localparam int PIPE_DEPTH = 5;

endpackage
`default_nettype wire

// File: hw/rtl/voigt_stress_rotation_core.sv
// Top level of the Voigt stress rotation core: basis registers, item pipeline.
// Depends on vsr_pkg, vsr_coef, vsr_mac.
//
// Usage:
//   Input: drive req_sig_* and raise start; the item is taken at a rising edge
//   with start high and busy low. busy is high only during reset, so one item
//   can be taken every cycle.
//   Output: each result sits on rsp_rot_* and rsp_clipped for one cycle with
//   rsp_valid high; it appears once its item has passed the input registers
//   and the partial-product, sum and output registers. The receiver cannot
//   stall; results must be taken when shown.
//   Throughput: one item per cycle, set by the fully pipelined multiplier
//   array (coefficient products, then 72 split partial products per item).
//   Configuration: csr_we writes csr_wdata into the basis column at
//   csr_index (from x, y, z, then to x, y, z); other indexes are ignored.
//   Write only while no item is in flight. R and T follow the registers through
//   r_ff and then t_ff, in step with the item pipeline.
//   Reset: both bases return to the identity and in-flight items are dropped.
`default_nettype none
module voigt_stress_rotation_core
   import vsr_pkg::*;
#(
   parameter int COS_FRAC_BITS = 14
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  stress_type  req_sig_xx,
   input  stress_type  req_sig_yy,
   input  stress_type  req_sig_zz,
   input  stress_type  req_sig_yz,
   input  stress_type  req_sig_zx,
   input  stress_type  req_sig_xy,
   output logic        rsp_valid,
   output stress_type  rsp_rot_xx,
   output stress_type  rsp_rot_yy,
   output stress_type  rsp_rot_zz,
   output stress_type  rsp_rot_yz,
   output stress_type  rsp_rot_zx,
   output stress_type  rsp_rot_xy,
   output logic        rsp_clipped,
   input  wire         csr_we,
   input  wire [2:0]   csr_index,
   input  wire [47:0]  csr_wdata
);

   localparam int RW = 34 - COS_FRAC_BITS;
   localparam int TW = 2 * RW + 1 - COS_FRAC_BITS;
   localparam basis_col_type ONE = 48'(1) << COS_FRAC_BITS;

   basis_col_type        from_col_ff [3];
   basis_col_type        to_col_ff [3];
   logic signed [TW-1:0] t [6][6];
   stress_type           sig_s1_ff [6];
   stress_type           sig_s2_ff [6];
   logic                 v_s1_ff;
   logic                 v_s2_ff;
   logic                 accept;
   stress_type           rot [6];

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         from_col_ff[0] <= ONE;
         from_col_ff[1] <= ONE << 16;
         from_col_ff[2] <= ONE << 32;
         to_col_ff[0]   <= ONE;
         to_col_ff[1]   <= ONE << 16;
         to_col_ff[2]   <= ONE << 32;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FROM_COL_X: from_col_ff[0] <= csr_wdata;
            CSR_FROM_COL_Y: from_col_ff[1] <= csr_wdata;
            CSR_FROM_COL_Z: from_col_ff[2] <= csr_wdata;
            CSR_TO_COL_X:   to_col_ff[0]   <= csr_wdata;
            CSR_TO_COL_Y:   to_col_ff[1]   <= csr_wdata;
            CSR_TO_COL_Z:   to_col_ff[2]   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      sig_s1_ff <= '{req_sig_xx, req_sig_yy, req_sig_zz,
                     req_sig_yz, req_sig_zx, req_sig_xy};
      sig_s2_ff <= sig_s1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_s1_ff <= 1'b0;
         v_s2_ff <= 1'b0;
      end else begin
         v_s1_ff <= accept;
         v_s2_ff <= v_s1_ff;
      end
   end

   vsr_coef #(.COS_FRAC_BITS(COS_FRAC_BITS)) u_coef (
      .clock    (clock),
      .from_col (from_col_ff),
      .to_col   (to_col_ff),
      .t_ff     (t)
   );

   vsr_mac #(.COS_FRAC_BITS(COS_FRAC_BITS)) u_mac (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (v_s2_ff),
      .t            (t),
      .sig          (sig_s2_ff),
      .out_valid_ff (rsp_valid),
      .rot_ff       (rot),
      .clipped_ff   (rsp_clipped)
   );

   assign rsp_rot_xx = rot[0];
   assign rsp_rot_yy = rot[1];
   assign rsp_rot_zz = rot[2];
   assign rsp_rot_yz = rot[3];
   assign rsp_rot_zx = rot[4];
   assign rsp_rot_xy = rot[5];

   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, PIPE_DEPTH))
      else $error("result without a taken item");

   a_item_has_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_DEPTH rsp_valid)
      else $error("taken item produced no result");

   a_zero_in_zero_out: assert property (@(posedge clock) disable iff (reset)
      (accept && req_sig_xx == 0 && req_sig_yy == 0 && req_sig_zz == 0 &&
       req_sig_yz == 0 && req_sig_zx == 0 && req_sig_xy == 0)
      |-> ##PIPE_DEPTH (rsp_rot_xx == 0 && rsp_rot_yy == 0 && rsp_rot_zz == 0 &&
          rsp_rot_yz == 0 && rsp_rot_zx == 0 && rsp_rot_xy == 0 && !rsp_clipped))
      else $error("zero stress did not give zero result");

   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
      (rsp_rot_xx == 32'sh7FFF_FFFF || rsp_rot_xx == 32'sh8000_0000 ||
       rsp_rot_yy == 32'sh7FFF_FFFF || rsp_rot_yy == 32'sh8000_0000 ||
       rsp_rot_zz == 32'sh7FFF_FFFF || rsp_rot_zz == 32'sh8000_0000 ||
       rsp_rot_yz == 32'sh7FFF_FFFF || rsp_rot_yz == 32'sh8000_0000 ||
       rsp_rot_zx == 32'sh7FFF_FFFF || rsp_rot_zx == 32'sh8000_0000 ||
       rsp_rot_xy == 32'sh7FFF_FFFF || rsp_rot_xy == 32'sh8000_0000))
      else $error("clip flag without a saturated component");

endmodule
`default_nettype wire

// File: hw/rtl/vsr_coef.sv
// Coefficient pipeline: direction cosines R, then the 6x6 Voigt transform T.
// Depends on vsr_pkg.
`default_nettype none
module vsr_coef
   import vsr_pkg::*;
#(
   parameter int COS_FRAC_BITS = 14,
   localparam int RW = 34 - COS_FRAC_BITS,
   localparam int EW = 2 * RW + 1,
   localparam int TW = EW - COS_FRAC_BITS
) (
   input  wire                  clock,
   input  basis_col_type        from_col [3],
   input  basis_col_type        to_col [3],
   output logic signed [TW-1:0] t_ff [6][6]
);

   localparam logic signed [33:0] RHALF = 34'sd1 <<< (COS_FRAC_BITS - 1);
   localparam logic signed [EW-1:0] EHALF = EW'(1) <<< (COS_FRAC_BITS - 1);

   logic signed [RW-1:0] r_ff [3][3];
   logic signed [RW-1:0] r_in [3][3];
   logic signed [TW-1:0] t_in [6][6];

   always_comb begin
      logic signed [33:0] acc;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            acc = '0;
            for (int k = 0; k < 3; k++) begin
               acc = acc + 34'($signed(to_col[i][16*k +: 16]) *
                               $signed(from_col[j][16*k +: 16]));
            end
            r_in[i][j] = RW'((acc + RHALF) >>> COS_FRAC_BITS);
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
   end

   always_comb begin
      logic signed [EW-1:0] e;
      for (int i = 0; i < 6; i++) begin
         for (int j = 0; j < 6; j++) begin
            if (VOIGT_P[j] == VOIGT_Q[j]) begin
               e = EW'(r_ff[VOIGT_P[i]][VOIGT_P[j]] * r_ff[VOIGT_Q[i]][VOIGT_P[j]]);
            end else begin
               e = EW'(r_ff[VOIGT_P[i]][VOIGT_P[j]] * r_ff[VOIGT_Q[i]][VOIGT_Q[j]])
                 + EW'(r_ff[VOIGT_P[i]][VOIGT_Q[j]] * r_ff[VOIGT_Q[i]][VOIGT_P[j]]);
            end
            t_in[i][j] = TW'((e + EHALF) >>> COS_FRAC_BITS);
         end
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in;
   end

endmodule
`default_nettype wire

// File: hw/rtl/vsr_mac.sv
// Transform datapath: split partial products, row sums, round and saturate.
// Depends on vsr_pkg.
`default_nettype none
module vsr_mac
   import vsr_pkg::*;
#(
   parameter int COS_FRAC_BITS = 14,
   localparam int RW = 34 - COS_FRAC_BITS,
   localparam int TW = 2 * RW + 1 - COS_FRAC_BITS
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   input  wire signed [TW-1:0]  t [6][6],
   input  stress_type           sig [6],
   output logic                 out_valid_ff,
   output stress_type           rot_ff [6],
   output logic                 clipped_ff
);

   localparam int HW = TW - 16;
   localparam int SW = TW + 32 + 3;
   localparam logic signed [SW-1:0] SHALF = SW'(1) <<< (COS_FRAC_BITS - 1);

   logic signed [48:0]      pp_lo_ff [6][6];
   logic signed [HW+31:0]   pp_hi_ff [6][6];
   logic signed [SW-1:0]    acc_ff [6];
   logic signed [SW-1:0]    acc_in [6];
   logic                    v_pp_ff;
   logic                    v_acc_ff;
   stress_type              rot_in [6];
   logic                    clipped_in;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 6; i++) begin
         for (int j = 0; j < 6; j++) begin
            pp_lo_ff[i][j] <= $signed({1'b0, t[i][j][15:0]}) * sig[j];
            pp_hi_ff[i][j] <= $signed(t[i][j][TW-1:16]) * sig[j];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         acc_in[i] = '0;
         for (int j = 0; j < 6; j++) begin
            acc_in[i] = acc_in[i] + (SW'(pp_hi_ff[i][j]) <<< 16) + SW'(pp_lo_ff[i][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   always_comb begin
      logic signed [SW-1:0] v;
      clipped_in = 1'b0;
      for (int i = 0; i < 6; i++) begin
         v = (acc_ff[i] + SHALF) >>> COS_FRAC_BITS;
         if ((&v[SW-1:31]) || !(|v[SW-1:31])) begin
            rot_in[i] = v[31:0];
         end else begin
            rot_in[i] = v[SW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            clipped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rot_ff     <= rot_in;
      clipped_ff <= clipped_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_pp_ff      <= 1'b0;
         v_acc_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v_pp_ff      <= in_valid;
         v_acc_ff     <= v_pp_ff;
         out_valid_ff <= v_acc_ff;
      end
   end

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for voigt_stress_rotation_core: rotates random and
// directed stress items under several basis settings against an internal predictor.
// Depends on vsr_pkg and the core RTL.
`default_nettype none
module testbench
   import vsr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 14;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = PIPE_DEPTH + 5;

   typedef struct {
      stress_type rot [6];
      logic       clipped;
   } rotated_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   stress_type  req_sig [6];
   logic        rsp_valid;
   stress_type  rsp_rot [6];
   logic        rsp_clipped;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [47:0] csr_wdata = '0;

   basis_col_type from_col [3];
   basis_col_type to_col [3];
   rotated_type   expected_q [$];
   int            fail_count = 0;
   int            idle_cycles = 0;
   logic          check_done = 0;

   initial foreach (req_sig[i]) req_sig[i] = '0;

   voigt_stress_rotation_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_sig_xx(req_sig[0]), .req_sig_yy(req_sig[1]), .req_sig_zz(req_sig[2]),
      .req_sig_yz(req_sig[3]), .req_sig_zx(req_sig[4]), .req_sig_xy(req_sig[5]),
      .rsp_valid(rsp_valid),
      .rsp_rot_xx(rsp_rot[0]), .rsp_rot_yy(rsp_rot[1]), .rsp_rot_zz(rsp_rot[2]),
      .rsp_rot_yz(rsp_rot[3]), .rsp_rot_zx(rsp_rot[4]), .rsp_rot_xy(rsp_rot[5]),
      .rsp_clipped(rsp_clipped),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // round half up, dropping FRAC bits
   function automatic longint round_frac(longint x);
      return (x + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic longint cos_entry(basis_col_type col, int k);
      logic signed [15:0] e;
      e = col[16*k +: 16];
      return longint'(e);
   endfunction

   function automatic rotated_type rotate_stress(stress_type sig [6]);
      longint dcm [3][3];
      longint xf [6][6];
      longint acc;
      int a, b, p, q;
      rotated_type res;
      res.clipped = 0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++)
               acc += cos_entry(to_col[i], k) * cos_entry(from_col[j], k);
            dcm[i][j] = round_frac(acc);
         end
      for (int i = 0; i < 6; i++) begin
         a = VOIGT_P[i];
         b = VOIGT_Q[i];
         for (int j = 0; j < 6; j++) begin
            p = VOIGT_P[j];
            q = VOIGT_Q[j];
            if (p == q) acc = dcm[a][p] * dcm[b][p];
            else acc = dcm[a][p] * dcm[b][q] + dcm[a][q] * dcm[b][p];
            xf[i][j] = round_frac(acc);
         end
      end
      for (int i = 0; i < 6; i++) begin
         acc = 0;
         for (int j = 0; j < 6; j++) acc += xf[i][j] * longint'(sig[j]);
         acc = round_frac(acc);
         if (acc > 64'sd2147483647) begin
            acc = 64'sd2147483647;
            res.clipped = 1;
         end
         if (acc < -64'sd2147483648) begin
            acc = -64'sd2147483648;
            res.clipped = 1;
         end
         res.rot[i] = stress_type'(acc);
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rotated_type exp_item;
      if (reset || check_done) begin
         idle_cycles <= 0;
      end else begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result", $time);
            fail_count++;
         end else begin
            exp_item = expected_q.pop_front();
            for (int i = 0; i < 6; i++)
               if (rsp_rot[i] !== exp_item.rot[i]) begin
                  $display("%0t: rot[%0d] expected %0d actual %0d", $time, i,
                           exp_item.rot[i], rsp_rot[i]);
                  fail_count++;
               end
            if (rsp_clipped !== exp_item.clipped) begin
               $display("%0t: clipped expected %0b actual %0b", $time,
                        exp_item.clipped, rsp_clipped);
               fail_count++;
            end
         end
      end
   end

   // start stays high between back-to-back items; it drops only before a gap
   task automatic send_stress(stress_type sig [6], int gap);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      foreach (sig[i]) req_sig[i] <= sig[i];
      do @(posedge clock); while (busy);
      expected_q.push_back(rotate_stress(sig));
   endtask

   task automatic wait_idle();
      start <= 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [47:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         CSR_FROM_COL_X: from_col[0] = val;
         CSR_FROM_COL_Y: from_col[1] = val;
         CSR_FROM_COL_Z: from_col[2] = val;
         CSR_TO_COL_X:   to_col[0] = val;
         CSR_TO_COL_Y:   to_col[1] = val;
         CSR_TO_COL_Z:   to_col[2] = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_bases(basis_col_type f [3], basis_col_type t [3]);
      write_csr(CSR_FROM_COL_X, f[0]);
      write_csr(CSR_FROM_COL_Y, f[1]);
      write_csr(CSR_FROM_COL_Z, f[2]);
      write_csr(CSR_TO_COL_X, t[0]);
      write_csr(CSR_TO_COL_Y, t[1]);
      write_csr(CSR_TO_COL_Z, t[2]);
   endtask

   function automatic stress_type rand_stress();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return stress_type'($urandom_range(0, 2000)) - 1000;
         default: return stress_type'($urandom);
      endcase
   endfunction

   task automatic test_directed_identity();
      stress_type sig [6];
      stress_type corner [4] = '{32'sh7fffffff, 32'sh80000000, 0, -1};
      for (int n = 0; n < 12; n++) begin
         foreach (sig[i]) sig[i] = corner[(n + i * (n / 4 + 1)) % 4];
         send_stress(sig, n % 3);
      end
      foreach (sig[i]) sig[i] = 0;
      sig[n_mod(0)] = 1000;
      send_stress(sig, 0);
      wait_idle();
   endtask

   function automatic int n_mod(int x);
      return x;
   endfunction

   task automatic test_directed_bases();
      basis_col_type f [3];
      basis_col_type t [3];
      stress_type sig [6];
      // 90 degree turn about z, then extreme entries (not orthonormal)
      f = '{48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000};
      t = '{48'h0000_4000_0000, 48'h0000_0000_C000, 48'h4000_0000_0000};
      set_bases(f, t);
      sig = '{100, 200, 300, 40, 50, 60};
      send_stress(sig, 0);
      sig = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 7, -7, 32'sh80000000};
      send_stress(sig, 1);
      wait_idle();
      f = '{48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'hFFFF_FFFF_FFFF};
      t = '{48'h8000_7FFF_8000, 48'h7FFF_7FFF_7FFF, 48'h0000_0000_0000};
      set_bases(f, t);
      for (int n = 0; n < 6; n++) begin
         foreach (sig[i]) sig[i] = (n % 2) ? 32'sh80000000 : 32'sh7fffffff;
         sig[n] = 12345;
         send_stress(sig, 0);
      end
      wait_idle();
      write_csr(3'd6, 48'h1234_5678_9ABC);
      write_csr(3'd7, 48'hFFFF_FFFF_FFFF);
      sig = '{1, -2, 3, -4, 5, -6};
      send_stress(sig, 0);
      wait_idle();
   endtask

   task automatic test_random();
      basis_col_type f [3];
      basis_col_type t [3];
      stress_type sig [6];
      for (int phase = 0; phase < 6; phase++) begin
         foreach (f[i]) begin
            f[i] = 48'({$urandom, $urandom});
            t[i] = 48'({$urandom, $urandom});
            if (phase % 2 == 0) begin
               f[i] = 48'h4000 << (16 * i);
               t[i] = 48'h4000 << (16 * ((i + phase / 2) % 3));
               t[i] = t[i] ^ (48'({$urandom, $urandom}) & 48'h00FF_00FF_00FF);
            end
         end
         set_bases(f, t);
         for (int n = 0; n < 250; n++) begin
            foreach (sig[i]) sig[i] = rand_stress();
            send_stress(sig, (n % 64 < 32) ? 0 : $urandom_range(0, 9));
         end
         wait_idle();
      end
   endtask

   initial begin
      foreach (from_col[i]) begin
         from_col[i] = 48'h4000 << (16 * i);
         to_col[i] = 48'h4000 << (16 * i);
      end
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed_identity();
      test_directed_bases();
      test_random();
      check_done = 1;
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
`default_nettype wire

// File: files.f
hw/rtl/vsr_pkg.sv
hw/rtl/vsr_coef.sv
hw/rtl/vsr_mac.sv
hw/rtl/voigt_stress_rotation_core.sv
tb/testbench.sv
